[rtl/mer_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the
// midpoint ellipse rasterizer. No dependencies.
package mer_pkg;

    localparam int COORD_BITS  = 12;
    localparam int RADIUS_BITS = 10;
    localparam int OUT_W       = COORD_BITS + 1;
    localparam int SQ_W        = 2 * RADIUS_BITS;
    localparam int CUBE_W      = 3 * RADIUS_BITS;
    // Decision, edge increments and implicit function value, all exact.
    localparam int DEC_W       = 4 * RADIUS_BITS + 4;
    localparam int SUM_W       = (OUT_W > RADIUS_BITS + 1) ? OUT_W : RADIUS_BITS + 1;
    localparam logic [RADIUS_BITS-1:0] X_MAX = {RADIUS_BITS{1'b1}};

    typedef enum logic [0:0] {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } t_command;

    typedef enum logic [8:0] {
        OP_NONE   = 9'b000000001,
        OP_LOAD   = 9'b000000010,
        OP_SQR    = 9'b000000100,
        OP_CUBE   = 9'b000001000,
        OP_DINIT  = 9'b000010000,
        OP_STEPA  = 9'b000100000,
        OP_ENTER1 = 9'b001000000,
        OP_ENTER2 = 9'b010000000,
        OP_STEPB  = 9'b100000000
    } t_op;

    typedef struct packed {
        t_op  op;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic active;
        logic need_enter;
        logic out_free;
    } t_sts;

endpackage

[rtl/midpoint_ellipse_rasterizer.sv]
// Midpoint ellipse rasterizer top level: sequencer plus datapath. Uses mer_pkg.
// Start request: load, square, cube and decision init. Step request: the two step
// halves, with the two region-entry operations before them on the step that enters
// the second region; a step with no ellipse running only loads. One request is taken
// at a time, one operation a cycle; a receiver holding a result stalls the next.
// Reset: synchronous, active low; idle with no ellipse and no pending result.
module midpoint_ellipse_rasterizer (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_command,
    input  logic signed [mer_pkg::COORD_BITS-1:0]  i_center_x,
    input  logic signed [mer_pkg::COORD_BITS-1:0]  i_center_y,
    input  logic        [mer_pkg::RADIUS_BITS-1:0] i_radius_x,
    input  logic        [mer_pkg::RADIUS_BITS-1:0] i_radius_y,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic                                   o_point_valid,
    output logic signed [mer_pkg::OUT_W-1:0]       o_x_minus,
    output logic signed [mer_pkg::OUT_W-1:0]       o_x_plus,
    output logic signed [mer_pkg::OUT_W-1:0]       o_y_minus,
    output logic signed [mer_pkg::OUT_W-1:0]       o_y_plus,
    output logic                                   o_last_step
);
    import mer_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer.
    mer_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // Datapath.
    mer_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_command     (i_command),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_radius_x    (i_radius_x),
        .i_radius_y    (i_radius_y),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_point_valid (o_point_valid),
        .o_x_minus     (o_x_minus),
        .o_x_plus      (o_x_plus),
        .o_y_minus     (o_y_minus),
        .o_y_plus      (o_y_plus),
        .o_last_step   (o_last_step)
    );

    // A result is never written over one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!o_out_valid || i_out_ready))
        else $error("result register overwritten while full");

    // An accepted request keeps the sequencer busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while previous one still in work");

    // The final step flag only comes with real points.
    a_last_has_points: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_step) |-> o_point_valid)
        else $error("last step flagged without valid points");

    // A request with no ellipse running reads as all zeros.
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_point_valid) |->
            (o_x_minus == '0 && o_x_plus == '0 && o_y_minus == '0 && o_y_plus == '0))
        else $error("idle result carries nonzero coordinates");

endmodule

[rtl/mer_ctrl.sv]
// Sequencer for the midpoint ellipse rasterizer: walks each request through
// its datapath operations. Depends on mer_pkg.
module mer_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_command,
    input  mer_pkg::t_sts     i_sts,
    output logic              o_in_ready,
    output mer_pkg::t_cmd     o_cmd
);
    import mer_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_SQR    = 8'b00000010,
        S_CUBE   = 8'b00000100,
        S_DINIT  = 8'b00001000,
        S_STEPA  = 8'b00010000,
        S_ENTER2 = 8'b00100000,
        S_STEPB  = 8'b01000000,
        S_DONE   = 8'b10000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and the operation issued to the datapath in this cycle.
    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NONE;
        o_cmd.emit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    if (i_command == CMD_START) begin
                        n_state = S_SQR;
                    end else if (i_sts.active) begin
                        n_state = S_STEPA;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SQR: begin
                o_cmd.op = OP_SQR;
                n_state  = S_CUBE;
            end
            S_CUBE: begin
                o_cmd.op = OP_CUBE;
                n_state  = S_DINIT;
            end
            S_DINIT: begin
                o_cmd.op = OP_DINIT;
                n_state  = S_DONE;
            end
            S_STEPA: begin
                if (i_sts.need_enter) begin
                    o_cmd.op = OP_ENTER1;
                    n_state  = S_ENTER2;
                end else begin
                    o_cmd.op = OP_STEPA;
                    n_state  = S_STEPB;
                end
            end
            S_ENTER2: begin
                o_cmd.op = OP_ENTER2;
                n_state  = S_STEPA;
            end
            S_STEPB: begin
                o_cmd.op = OP_STEPB;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/mer_dp.sv]
// Datapath of the midpoint ellipse rasterizer: geometry, incremental decision
// arithmetic and the output register. Depends on mer_pkg.
module mer_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mer_pkg::t_cmd                       i_cmd,
    output mer_pkg::t_sts                       o_sts,
    input  logic                                i_command,
    input  logic signed [mer_pkg::COORD_BITS-1:0]  i_center_x,
    input  logic signed [mer_pkg::COORD_BITS-1:0]  i_center_y,
    input  logic        [mer_pkg::RADIUS_BITS-1:0] i_radius_x,
    input  logic        [mer_pkg::RADIUS_BITS-1:0] i_radius_y,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_point_valid,
    output logic signed [mer_pkg::OUT_W-1:0]    o_x_minus,
    output logic signed [mer_pkg::OUT_W-1:0]    o_x_plus,
    output logic signed [mer_pkg::OUT_W-1:0]    o_y_minus,
    output logic signed [mer_pkg::OUT_W-1:0]    o_y_plus,
    output logic                                o_last_step
);
    import mer_pkg::*;

    // Geometry and position.
    logic signed [COORD_BITS-1:0]  r_cx;
    logic signed [COORD_BITS-1:0]  r_cy;
    logic        [RADIUS_BITS-1:0] r_rx;
    logic        [RADIUS_BITS-1:0] r_x;
    logic        [RADIUS_BITS-1:0] r_y;
    logic        [SQ_W-1:0]        r_a2;
    logic        [SQ_W-1:0]        r_b2;
    // px = 8*b2*x, py = 8*a2*y, q = b2*x^2 + a2*y^2 - a2*b2, dec = decision.
    logic signed [DEC_W-1:0]       r_px;
    logic signed [DEC_W-1:0]       r_py;
    logic signed [DEC_W-1:0]       r_q;
    logic signed [DEC_W-1:0]       r_dec;
    logic                          r_active;
    logic                          r_reg2;
    logic                          r_pv;
    logic                          r_last;
    // Branch taken in the first half of a step, used by the second half.
    logic                          r_r1;
    logic                          r_addpx;
    logic                          r_dy;
    // Output register.
    logic                          r_out_valid;
    logic                          r_o_pv;
    logic                          r_o_last;
    logic        [OUT_W-1:0]       r_o_xm;
    logic        [OUT_W-1:0]       r_o_xp;
    logic        [OUT_W-1:0]       r_o_ym;
    logic        [OUT_W-1:0]       r_o_yp;

    logic        [CUBE_W-1:0]      cube;
    logic signed [DEC_W-1:0]       a2_e;
    logic signed [DEC_W-1:0]       b2_e;
    logic signed [DEC_W-1:0]       a2x4;
    logic signed [DEC_W-1:0]       b2x4;
    logic signed [DEC_W-1:0]       a2x8;
    logic signed [DEC_W-1:0]       b2x8;
    logic signed [DEC_W-1:0]       n_dec;
    logic                          d_neg;
    logic                          d_pos;
    logic                          r1_test;
    logic                          bx;
    logic                          dy;
    logic signed [SUM_W-1:0]       cx_e;
    logic signed [SUM_W-1:0]       cy_e;
    logic signed [SUM_W-1:0]       x_e;
    logic signed [SUM_W-1:0]       y_e;
    logic signed [SUM_W-1:0]       xm;
    logic signed [SUM_W-1:0]       xp;
    logic signed [SUM_W-1:0]       ym;
    logic signed [SUM_W-1:0]       yp;

    // Scaled squared radii as signed decision-width terms.
    assign a2_e = $signed({{(DEC_W - SQ_W){1'b0}}, r_a2});
    assign b2_e = $signed({{(DEC_W - SQ_W){1'b0}}, r_b2});
    assign a2x4 = a2_e <<< 2;
    assign b2x4 = b2_e <<< 2;
    assign a2x8 = a2_e <<< 3;
    assign b2x8 = b2_e <<< 3;
    assign cube = CUBE_W'(r_a2) * CUBE_W'(r_y);

    // Region one holds while b2*x < a2*y, compared on the scaled increments.
    assign d_neg   = r_dec[DEC_W-1];
    assign d_pos   = !d_neg && (r_dec != '0);
    assign r1_test = !r_reg2 && (r_px < r_py);
    assign bx      = r1_test ? 1'b1 : !d_pos;
    assign dy      = r1_test ? !d_neg : 1'b1;

    // Second half of a step: decision update from the new increments.
    assign n_dec = r_dec + (r_r1 ? b2x4 : a2x4) + (r_addpx ? r_px : '0)
                   - (r_dy ? r_py : '0);

    assign o_sts.active     = r_active;
    assign o_sts.need_enter = !r_reg2 && !(r_px < r_py);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    // Mirrored coordinates, wrapped to the output width.
    assign cx_e = SUM_W'(r_cx);
    assign cy_e = SUM_W'(r_cy);
    assign x_e  = $signed({{(SUM_W - RADIUS_BITS){1'b0}}, r_x});
    assign y_e  = $signed({{(SUM_W - RADIUS_BITS){1'b0}}, r_y});
    assign xm   = cx_e - x_e;
    assign xp   = cx_e + x_e;
    assign ym   = cy_e - y_e;
    assign yp   = cy_e + y_e;

    // Control flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_reg2   <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                OP_LOAD: begin
                    if (i_command == CMD_START) begin
                        r_active <= (i_radius_y != '0);
                        r_reg2   <= 1'b0;
                    end
                end
                OP_STEPA: begin
                    if (dy && (r_y == RADIUS_BITS'(1))) begin
                        r_active <= 1'b0;
                    end
                end
                OP_ENTER2: begin
                    r_reg2 <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Geometry, increments and decision.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                if (i_command == CMD_START) begin
                    r_cx   <= i_center_x;
                    r_cy   <= i_center_y;
                    r_rx   <= i_radius_x;
                    r_x    <= '0;
                    r_y    <= i_radius_y;
                    r_px   <= '0;
                    r_q    <= '0;
                    r_pv   <= 1'b1;
                    r_last <= (i_radius_y == '0);
                end else begin
                    r_pv   <= r_active;
                    r_last <= 1'b0;
                end
            end
            OP_SQR: begin
                r_a2 <= SQ_W'(r_rx) * SQ_W'(r_rx);
                r_b2 <= SQ_W'(r_y) * SQ_W'(r_y);
            end
            OP_CUBE: begin
                r_py <= $signed({{(DEC_W - CUBE_W - 3){1'b0}}, cube, 3'b000});
            end
            OP_DINIT: begin
                r_dec <= b2x4 - (r_py >>> 1) + a2_e;
            end
            OP_STEPA: begin
                r_r1    <= r1_test;
                r_addpx <= bx;
                r_dy    <= dy;
                r_last  <= dy && (r_y == RADIUS_BITS'(1));
                if (bx && (r_x != X_MAX)) begin
                    r_x  <= r_x + RADIUS_BITS'(1);
                    r_px <= r_px + b2x8;
                    r_q  <= r_q + (r_px >>> 2) + b2_e;
                end
                if (dy) begin
                    r_y  <= r_y - RADIUS_BITS'(1);
                    r_py <= r_py - a2x8;
                end
            end
            OP_ENTER1: begin
                r_dec <= (r_q <<< 2) + (r_px >>> 1) + b2_e;
            end
            OP_ENTER2: begin
                r_dec <= r_dec + a2x4 - r_py;
            end
            OP_STEPB: begin
                r_dec <= n_dec;
                if (r_dy) begin
                    r_q <= r_q - a2_e - (r_py >>> 2);
                end
            end
            OP_NONE: begin
            end
            default: begin
            end
        endcase
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload; a request that finds no ellipse reads as zeros.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_pv   <= r_pv;
            r_o_last <= r_pv && r_last;
            r_o_xm   <= r_pv ? xm[OUT_W-1:0] : '0;
            r_o_xp   <= r_pv ? xp[OUT_W-1:0] : '0;
            r_o_ym   <= r_pv ? ym[OUT_W-1:0] : '0;
            r_o_yp   <= r_pv ? yp[OUT_W-1:0] : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_point_valid = r_o_pv;
    assign o_last_step   = r_o_last;
    assign o_x_minus     = $signed(r_o_xm);
    assign o_x_plus      = $signed(r_o_xp);
    assign o_y_minus     = $signed(r_o_ym);
    assign o_y_plus      = $signed(r_o_yp);

endmodule

[tb/ellipse_point_checker.sv]
// Checker for the midpoint ellipse rasterizer: predicts the four mirrored points
// of every accepted request and compares them with the results that leave the block.
// Depends on mer_pkg for widths and command codes.
module ellipse_point_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_ready,
    input  logic                                   i_command,
    input  logic signed [mer_pkg::COORD_BITS-1:0]  i_center_x,
    input  logic signed [mer_pkg::COORD_BITS-1:0]  i_center_y,
    input  logic        [mer_pkg::RADIUS_BITS-1:0] i_radius_x,
    input  logic        [mer_pkg::RADIUS_BITS-1:0] i_radius_y,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_ready,
    input  logic                                   i_point_valid,
    input  logic signed [mer_pkg::OUT_W-1:0]       i_x_minus,
    input  logic signed [mer_pkg::OUT_W-1:0]       i_x_plus,
    input  logic signed [mer_pkg::OUT_W-1:0]       i_y_minus,
    input  logic signed [mer_pkg::OUT_W-1:0]       i_y_plus,
    input  logic                                   i_last_step,
    output int                                     o_fail_count,
    output int                                     o_outstanding,
    output int                                     o_checked,
    output logic                                   o_ellipse_running
);
    timeunit 1ns;
    timeprecision 1ps;
    import mer_pkg::*;

    localparam int PRINT_CAP = 200;

    typedef struct packed {
        logic                    point_valid;
        logic signed [OUT_W-1:0] x_minus;
        logic signed [OUT_W-1:0] x_plus;
        logic signed [OUT_W-1:0] y_minus;
        logic signed [OUT_W-1:0] y_plus;
        logic                    last_step;
    } t_points;

    // Rasterizer state as the predictor sees it; decision terms are scaled by four.
    longint pt_x, pt_y, dec;
    longint org_x, org_y, rx_sq, ry_sq;
    logic   second_half;
    logic   running;

    t_points expected_points[$];
    int      fail_count = 0;
    int      waiting = 0;
    int      checked = 0;

    assign o_fail_count      = fail_count;
    assign o_outstanding     = waiting;
    assign o_checked         = checked;
    assign o_ellipse_running = running;

    task automatic report_mismatch(input string detail);
        if (fail_count < PRINT_CAP)
            $display("[%0t] result %0d: %s", $realtime, checked, detail);
        fail_count++;
    endtask

    // The four mirrored points at the current offset, wrapped to the output width.
    function automatic t_points place_points(input logic valid, input logic last);
        t_points pts;
        longint  v;
        pts.point_valid = valid;
        v = org_x - pt_x;
        pts.x_minus = v[OUT_W-1:0];
        v = org_x + pt_x;
        pts.x_plus = v[OUT_W-1:0];
        v = org_y - pt_y;
        pts.y_minus = v[OUT_W-1:0];
        v = org_y + pt_y;
        pts.y_plus = v[OUT_W-1:0];
        pts.last_step = last;
        return pts;
    endfunction

    // The x offset saturates at the largest radius.
    task automatic advance_x();
        if (pt_x < longint'(X_MAX))
            pt_x++;
    endtask

    task automatic clear_state();
        pt_x = 0;
        pt_y = 0;
        dec = 0;
        org_x = 0;
        org_y = 0;
        rx_sq = 0;
        ry_sq = 0;
        second_half = 1'b0;
        running = 1'b0;
    endtask

    // Applies one request to the predicted state and gives the result it causes.
    task automatic predict_points(
        input  t_command                      cmd,
        input  logic signed [COORD_BITS-1:0]  cx,
        input  logic signed [COORD_BITS-1:0]  cy,
        input  logic        [RADIUS_BITS-1:0] rx,
        input  logic        [RADIUS_BITS-1:0] ry,
        output t_points                       pts
    );
        longint a2, b2, x0, y0, ryl;
        logic   done;
        pts = '0;
        if (cmd == CMD_START) begin
            ryl = longint'(ry);
            org_x = longint'(cx);
            org_y = longint'(cy);
            rx_sq = longint'(rx) * longint'(rx);
            ry_sq = ryl * ryl;
            pt_x = 0;
            pt_y = ryl;
            second_half = 1'b0;
            dec = 4 * ry_sq - 4 * rx_sq * ryl + rx_sq;
            running = (ryl != 0);
            pts = place_points(1'b1, ryl == 0);
        end else if (running) begin
            a2 = rx_sq;
            b2 = ry_sq;
            x0 = pt_x;
            y0 = pt_y;
            if (!second_half && b2 * x0 < a2 * y0) begin
                // First region: x always moves, y only when the midpoint is outside.
                advance_x();
                if (dec < 0) begin
                    dec += 8 * b2 * pt_x + 4 * b2;
                end else begin
                    pt_y--;
                    dec += 8 * b2 * pt_x + 4 * b2 - 8 * a2 * pt_y;
                end
            end else begin
                // Second region: the decision is rebuilt once on entry.
                if (!second_half) begin
                    second_half = 1'b1;
                    dec = b2 * (2 * x0 + 1) * (2 * x0 + 1) + 4 * a2 * (y0 - 1) * (y0 - 1)
                          - 4 * a2 * b2;
                end
                if (dec > 0) begin
                    pt_y--;
                    dec += 4 * a2 - 8 * a2 * pt_y;
                end else begin
                    advance_x();
                    pt_y--;
                    dec += 8 * b2 * pt_x - 8 * a2 * pt_y + 4 * a2;
                end
            end
            done = (pt_y == 0);
            if (done)
                running = 1'b0;
            pts = place_points(1'b1, done);
        end
    endtask

    task automatic compare_points(input t_points want, input t_points got);
        if (got.point_valid !== want.point_valid)
            report_mismatch($sformatf("point_valid expected %0d got %0b",
                                      want.point_valid, got.point_valid));
        if (got.x_minus !== want.x_minus)
            report_mismatch($sformatf("x_minus expected %0d got %0d", want.x_minus, got.x_minus));
        if (got.x_plus !== want.x_plus)
            report_mismatch($sformatf("x_plus expected %0d got %0d", want.x_plus, got.x_plus));
        if (got.y_minus !== want.y_minus)
            report_mismatch($sformatf("y_minus expected %0d got %0d", want.y_minus, got.y_minus));
        if (got.y_plus !== want.y_plus)
            report_mismatch($sformatf("y_plus expected %0d got %0d", want.y_plus, got.y_plus));
        if (got.last_step !== want.last_step)
            report_mismatch($sformatf("last_step expected %0d got %0b",
                                      want.last_step, got.last_step));
    endtask

    initial clear_state();

    // Predict on each accepted request, check each accepted result in order.
    always @(posedge i_clk) begin : watch
        t_points want;
        t_points got;
        if (!i_rst_n) begin
            clear_state();
            expected_points.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                predict_points(t_command'(i_command), i_center_x, i_center_y,
                               i_radius_x, i_radius_y, want);
                expected_points.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                got.point_valid = i_point_valid;
                got.x_minus     = i_x_minus;
                got.x_plus      = i_x_plus;
                got.y_minus     = i_y_minus;
                got.y_plus      = i_y_plus;
                got.last_step   = i_last_step;
                if (expected_points.size() == 0) begin
                    report_mismatch("result arrived with no request waiting for it");
                end else begin
                    want = expected_points.pop_front();
                    compare_points(want, got);
                    checked++;
                end
            end
        end
        waiting = expected_points.size();
    end

endmodule

[tb/midpoint_ellipse_rasterizer_test.sv]
// Top of the midpoint ellipse rasterizer testbench: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on mer_pkg, the rasterizer and
// ellipse_point_checker.
module midpoint_ellipse_rasterizer_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mer_pkg::*;

    localparam int RUN_LIMIT     = 500000;
    localparam int RANDOM_ITEMS  = 1700;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int COORD_MIN     = -(2 ** (COORD_BITS - 1));
    localparam int COORD_MAX     = 2 ** (COORD_BITS - 1) - 1;
    localparam int RADIUS_MAX    = 2 ** RADIUS_BITS - 1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic                          command = CMD_START;
    logic signed [COORD_BITS-1:0]  center_x = '0;
    logic signed [COORD_BITS-1:0]  center_y = '0;
    logic        [RADIUS_BITS-1:0] radius_x = '0;
    logic        [RADIUS_BITS-1:0] radius_y = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic                          point_valid;
    logic signed [OUT_W-1:0]       x_minus, x_plus, y_minus, y_plus;
    logic                          last_step;

    int   failures, outstanding, checked;
    logic ellipse_running;

    logic quiet = 1'b0;
    logic holding = 1'b0;
    event hold_trigger;
    int   cycles = 0;
    int   starts_sent = 0;
    int   steps_sent = 0;
    int   idle_steps_sent = 0;

    always #1 clk = ~clk;

    midpoint_ellipse_rasterizer dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_command     (command),
        .i_center_x    (center_x),
        .i_center_y    (center_y),
        .i_radius_x    (radius_x),
        .i_radius_y    (radius_y),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_point_valid (point_valid),
        .o_x_minus     (x_minus),
        .o_x_plus      (x_plus),
        .o_y_minus     (y_minus),
        .o_y_plus      (y_plus),
        .o_last_step   (last_step)
    );

    ellipse_point_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_command         (command),
        .i_center_x        (center_x),
        .i_center_y        (center_y),
        .i_radius_x        (radius_x),
        .i_radius_y        (radius_y),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_point_valid     (point_valid),
        .i_x_minus         (x_minus),
        .i_x_plus          (x_plus),
        .i_y_minus         (y_minus),
        .i_y_plus          (y_plus),
        .i_last_step       (last_step),
        .o_fail_count      (failures),
        .o_outstanding     (outstanding),
        .o_checked         (checked),
        .o_ellipse_running (ellipse_running)
    );

    // Result side: random back-pressure, none in the quiet stretch, and the receiver
    // taking nothing while a hold-off is running.
    always @(negedge clk) begin
        if (holding)
            out_ready <= 1'b0;
        else if (quiet)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 27);
    end

    // Long receiver hold-off, counted here so the sender keeps offering requests.
    initial begin
        forever begin
            @(hold_trigger);
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            holding <= 1'b0;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("midpoint_ellipse_rasterizer verification failed");
            $finish;
        end
    end

    function automatic logic [COORD_BITS-1:0] any_coord();
        return COORD_BITS'($urandom_range((1 << COORD_BITS) - 1));
    endfunction

    function automatic logic [RADIUS_BITS-1:0] any_radius();
        return RADIUS_BITS'($urandom_range(RADIUS_MAX));
    endfunction

    // Offers one request after a random gap and holds it until it is accepted.
    // Entered and left at a falling edge.
    task automatic send_request(
        input t_command                      cmd,
        input logic signed [COORD_BITS-1:0]  cx,
        input logic signed [COORD_BITS-1:0]  cy,
        input logic        [RADIUS_BITS-1:0] rx,
        input logic        [RADIUS_BITS-1:0] ry
    );
        int pause;
        pause = 0;
        if (cmd == CMD_START)
            starts_sent++;
        else if (ellipse_running)
            steps_sent++;
        else
            idle_steps_sent++;
        while (!quiet && pause < 12 && $urandom_range(99) < 27) begin
            in_valid <= 1'b0;
            pause++;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        center_x <= cx;
        center_y <= cy;
        radius_x <= rx;
        radius_y <= ry;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // A step request carries random geometry, which the block must ignore.
    task automatic send_step();
        send_request(CMD_STEP, any_coord(), any_coord(), any_radius(), any_radius());
    endtask

    task automatic trace_to_end(input int cap);
        int n;
        n = 0;
        while (ellipse_running && n < cap) begin
            send_step();
            n++;
        end
    endtask

    // Stops offering until every expected result has been delivered.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
    endtask

    initial begin
        int                     ellipse_no;
        int                     goal;
        int                     sel;
        logic [RADIUS_BITS-1:0] rx, ry;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: idle step, flat ellipse, largest geometry, restart, small shapes.
        send_step();
        send_request(CMD_START, COORD_BITS'(COORD_MIN), COORD_BITS'(COORD_MAX),
                     RADIUS_BITS'(RADIUS_MAX), RADIUS_BITS'(0));
        send_step();
        send_request(CMD_START, COORD_BITS'(COORD_MAX), COORD_BITS'(COORD_MIN),
                     RADIUS_BITS'(RADIUS_MAX), RADIUS_BITS'(RADIUS_MAX));
        repeat (6) send_step();
        send_request(CMD_START, COORD_BITS'(0), COORD_BITS'(0),
                     RADIUS_BITS'(0), RADIUS_BITS'(3));
        trace_to_end(8);
        send_request(CMD_START, COORD_BITS'(-1), COORD_BITS'(-1),
                     RADIUS_BITS'(3), RADIUS_BITS'(2));
        trace_to_end(8);
        send_request(CMD_START, COORD_BITS'(5), COORD_BITS'(-5),
                     RADIUS_BITS'(1), RADIUS_BITS'(1));
        trace_to_end(4);
        send_step();

        // Random ellipses, mostly traced to the end, some cut short by a restart.
        ellipse_no = 0;
        goal = starts_sent + steps_sent + RANDOM_ITEMS;
        while (starts_sent + steps_sent < goal) begin
            ellipse_no++;
            if (ellipse_no == 20)
                quiet <= 1'b1;
            if (ellipse_no == 35)
                quiet <= 1'b0;
            if (ellipse_no == 45)
                -> hold_trigger;
            if (ellipse_no == 60)
                wait_for_drain();

            sel = $urandom_range(99);
            if (ellipse_no == 10) begin
                rx = RADIUS_BITS'($urandom_range(200, 320));
                ry = RADIUS_BITS'($urandom_range(200, 320));
            end else if (sel < 12) begin
                rx = RADIUS_BITS'($urandom_range(25, 120));
                ry = RADIUS_BITS'($urandom_range(25, 120));
            end else if (sel < 20) begin
                rx = RADIUS_BITS'($urandom_range(1));
                ry = RADIUS_BITS'($urandom_range(40));
                if ($urandom_range(1)) begin
                    rx = ry;
                    ry = RADIUS_BITS'($urandom_range(1));
                end
            end else begin
                rx = RADIUS_BITS'($urandom_range(24));
                ry = RADIUS_BITS'($urandom_range(24));
            end
            send_request(CMD_START, any_coord(), any_coord(), rx, ry);

            sel = $urandom_range(99);
            if (sel < 8) begin
                repeat ($urandom_range(5)) send_step();
            end else begin
                trace_to_end(5000);
                if (sel >= 90)
                    repeat ($urandom_range(1, 3)) send_step();
            end
        end

        // Let every result come home, then allow for the block's own latency.
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Ran %0d ellipse starts and %0d steps on running ellipses, plus %0d steps",
                 starts_sent, steps_sent, idle_steps_sent);
        $display("with no ellipse running; %0d results checked across a hold-off and a drain.",
                 checked);
        if (failures == 0 && outstanding == 0)
            $display("midpoint_ellipse_rasterizer verification clean");
        else
            $display("midpoint_ellipse_rasterizer verification failed");
        $finish;
    end

endmodule

[sim.f]
rtl/mer_pkg.sv
rtl/mer_ctrl.sv
rtl/mer_dp.sv
rtl/midpoint_ellipse_rasterizer.sv
tb/ellipse_point_checker.sv
tb/midpoint_ellipse_rasterizer_test.sv
